// ===== rtl/udta_pkg.sv =====
// shared constants for the unsigned decimal to ascii converter
// no dependencies; used by every module of the block by scoped names
`timescale 1ns / 1ps

package udta_pkg;

    // default configuration
    localparam int VALUE_WIDTH_DEF = 32;
    localparam int MAX_DIGITS_DEF  = 10;

    // binary bits folded into the bcd word by one pipeline stage
    localparam int STEP_BITS = 4;

    // one bcd digit
    localparam int DIGIT_W = 4;

    // double-dabble correction: a digit of five or more gets three added before the shift
    localparam logic [DIGIT_W-1:0] DABBLE_LIMIT = 4'd5;
    localparam logic [DIGIT_W-1:0] DABBLE_ADJ   = 4'd3;

    // ascii code of the character zero, at the width of the character field
    localparam int                 CHAR_W     = 6;
    localparam logic [CHAR_W-1:0]  ASCII_ZERO = 6'd48;

endpackage

// ===== rtl/udta_dabble_stage.sv =====
// one pipeline stage of the binary to bcd conversion (double dabble)
// folds a few binary bits into the bcd word; depends on udta_pkg
`timescale 1ns / 1ps

module udta_dabble_stage #(
    parameter int VALUE_WIDTH = udta_pkg::VALUE_WIDTH_DEF,
    parameter int MAX_DIGITS  = udta_pkg::MAX_DIGITS_DEF,
    parameter int STEPS       = udta_pkg::STEP_BITS
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   in_valid,
    input  logic [VALUE_WIDTH-1:0]                 in_val,
    input  logic [MAX_DIGITS*udta_pkg::DIGIT_W-1:0] in_bcd,
    input  logic                                   in_ovf,
    output logic                                   ready,
    output logic                                   out_valid,
    output logic [VALUE_WIDTH-1:0]                 out_val,
    output logic [MAX_DIGITS*udta_pkg::DIGIT_W-1:0] out_bcd,
    output logic                                   out_ovf,
    input  logic                                   out_ready
);

    localparam int BCD_W = MAX_DIGITS * udta_pkg::DIGIT_W;

    logic                   valid_reg;
    logic [VALUE_WIDTH-1:0] val_reg;
    logic [BCD_W-1:0]       bcd_reg;
    logic                   ovf_reg;

    logic [VALUE_WIDTH-1:0] val_next;
    logic [BCD_W-1:0]       bcd_next;
    logic                   ovf_next;

    always_comb
    begin
        val_next = in_val;
        bcd_next = in_bcd;
        ovf_next = in_ovf;
        for (int s = 0; s < STEPS; s++)
        begin
            for (int d = 0; d < MAX_DIGITS; d++)
            begin
                if (bcd_next[d*udta_pkg::DIGIT_W +: udta_pkg::DIGIT_W] >= udta_pkg::DABBLE_LIMIT)
                begin
                    bcd_next[d*udta_pkg::DIGIT_W +: udta_pkg::DIGIT_W] =
                        bcd_next[d*udta_pkg::DIGIT_W +: udta_pkg::DIGIT_W] + udta_pkg::DABBLE_ADJ;
                end
            end
            // a carry out of the top digit means more digits than we keep
            ovf_next = ovf_next | bcd_next[BCD_W-1];
            bcd_next = {bcd_next[BCD_W-2:0], val_next[VALUE_WIDTH-1]};
            val_next = {val_next[VALUE_WIDTH-2:0], 1'b0};
        end
    end

    assign ready = !valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ready && in_valid)
        begin
            val_reg <= val_next;
            bcd_reg <= bcd_next;
            ovf_reg <= ovf_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_val   = val_reg;
    assign out_bcd   = bcd_reg;
    assign out_ovf   = ovf_reg;

endmodule

// ===== rtl/udta_emit.sv =====
// digit emitter: holds one bcd word and sends its digits, leading one first
// finds the leading digit on load; depends on udta_pkg
`timescale 1ns / 1ps

module udta_emit #(
    parameter int MAX_DIGITS = udta_pkg::MAX_DIGITS_DEF
) (
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  logic                                    in_valid,
    input  logic [MAX_DIGITS*udta_pkg::DIGIT_W-1:0] in_bcd,
    input  logic                                    in_ovf,
    output logic                                    ready,
    output logic                                    digit_valid,
    input  logic                                    digit_stall,
    output logic [udta_pkg::CHAR_W-1:0]             digit_char,
    output logic                                    last_digit
);

    localparam int BCD_W = MAX_DIGITS * udta_pkg::DIGIT_W;
    localparam int IDX_W = $clog2(MAX_DIGITS);

    logic                valid_reg;
    logic [BCD_W-1:0]    bcd_reg;
    logic [IDX_W-1:0]    idx_reg;
    logic [IDX_W-1:0]    idx_next;
    logic [IDX_W-1:0]    lead;
    logic                done;
    logic                load;
    logic [udta_pkg::DIGIT_W-1:0] cur_digit;

    // position of the leading digit; all digits when the number was cut short
    always_comb
    begin
        lead = '0;
        for (int d = 0; d < MAX_DIGITS; d++)
        begin
            if (in_bcd[d*udta_pkg::DIGIT_W +: udta_pkg::DIGIT_W] != '0)
            begin
                lead = IDX_W'(d);
            end
        end
        if (in_ovf)
        begin
            lead = IDX_W'(MAX_DIGITS - 1);
        end
    end

    // final transfer of the current number
    assign done  = valid_reg && !digit_stall && (idx_reg == '0);
    assign ready = !valid_reg || done;
    assign load  = ready && in_valid;

    always_comb
    begin
        idx_next = idx_reg;
        if (load)
        begin
            idx_next = lead;
        end
        else if (valid_reg && !digit_stall && (idx_reg != '0))
        begin
            idx_next = idx_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            idx_reg   <= '0;
        end
        else
        begin
            idx_reg <= idx_next;
            if (ready)
            begin
                valid_reg <= in_valid;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            bcd_reg <= in_bcd;
        end
    end

    assign cur_digit   = bcd_reg[idx_reg*udta_pkg::DIGIT_W +: udta_pkg::DIGIT_W];
    assign digit_valid = valid_reg;
    assign digit_char  = udta_pkg::ASCII_ZERO
                         + {{(udta_pkg::CHAR_W-udta_pkg::DIGIT_W){1'b0}}, cur_digit};
    assign last_digit  = (idx_reg == '0);

endmodule

// ===== rtl/unsigned_decimal_to_ascii.sv =====
// top level of the unsigned binary to decimal ascii converter
// uses udta_pkg, udta_dabble_stage and udta_emit
`timescale 1ns / 1ps

// usage
//   value channel: value_valid / value_stall / value. one transfer carries one
//   unsigned number; it is taken at a clock edge with value_valid high and
//   value_stall low.
//   digit channel: digit_valid / digit_stall / digit_char / last_digit. each
//   transfer carries one ascii digit, most significant first, no leading
//   zeros; last_digit marks the final digit. zero gives a single '0'.
//   path: the first digit of a number passes one register per dabble stage
//   and then the emitter register.
//   throughput: one digit per cycle while digit_stall is low; a number holds the
//   digit emitter until its last digit is taken, and has 1 to MAX_DIGITS digits
//   (1 to 10 at 32 bits). the conversion pipeline (four bits of double dabble per
//   stage) takes a new number every cycle until every stage is occupied.
//   stall: when digit_stall is high the shown digit holds, the pipeline fills
//   behind it, and value_stall rises once every stage is occupied.
//   reset: rst_n clears all valid bits; nothing is carried between numbers.
//   a number with more than MAX_DIGITS digits gives its low MAX_DIGITS digits.

module unsigned_decimal_to_ascii #(
    parameter int VALUE_WIDTH = udta_pkg::VALUE_WIDTH_DEF,
    parameter int MAX_DIGITS  = udta_pkg::MAX_DIGITS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          value_valid,
    output logic                          value_stall,
    input  logic [VALUE_WIDTH-1:0]        value,
    output logic                          digit_valid,
    input  logic                          digit_stall,
    output logic [udta_pkg::CHAR_W-1:0]   digit_char,
    output logic                          last_digit
);

    localparam int BCD_W      = MAX_DIGITS * udta_pkg::DIGIT_W;
    localparam int NUM_STAGES = (VALUE_WIDTH + udta_pkg::STEP_BITS - 1) / udta_pkg::STEP_BITS;

    // index 0 is the input port, index k is the output of stage k-1
    logic                   st_valid [0:NUM_STAGES];
    logic                   st_ready [0:NUM_STAGES];
    logic [VALUE_WIDTH-1:0] st_val   [0:NUM_STAGES];
    logic [BCD_W-1:0]       st_bcd   [0:NUM_STAGES];
    logic                   st_ovf   [0:NUM_STAGES];

    assign st_valid[0]  = value_valid;
    assign st_val[0]    = value;
    assign st_bcd[0]    = '0;
    assign st_ovf[0]    = 1'b0;
    assign value_stall  = !st_ready[0];

    // conversion pipeline: four binary bits per stage, the last stage takes the rest
    for (genvar g = 0; g < NUM_STAGES; g++)
    begin : g_stage
        localparam int LEFT  = VALUE_WIDTH - g * udta_pkg::STEP_BITS;
        localparam int STEPS = (LEFT < udta_pkg::STEP_BITS) ? LEFT : udta_pkg::STEP_BITS;

        udta_dabble_stage #(
            .VALUE_WIDTH (VALUE_WIDTH),
            .MAX_DIGITS  (MAX_DIGITS),
            .STEPS       (STEPS)
        ) u_stage (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_valid  (st_valid[g]),
            .in_val    (st_val[g]),
            .in_bcd    (st_bcd[g]),
            .in_ovf    (st_ovf[g]),
            .ready     (st_ready[g]),
            .out_valid (st_valid[g+1]),
            .out_val   (st_val[g+1]),
            .out_bcd   (st_bcd[g+1]),
            .out_ovf   (st_ovf[g+1]),
            .out_ready (st_ready[g+1])
        );
    end

    // digit emitter takes the finished bcd word; the binary remainder is spent by now
    udta_emit #(
        .MAX_DIGITS (MAX_DIGITS)
    ) u_emit (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (st_valid[NUM_STAGES]),
        .in_bcd      (st_bcd[NUM_STAGES]),
        .in_ovf      (st_ovf[NUM_STAGES]),
        .ready       (st_ready[NUM_STAGES]),
        .digit_valid (digit_valid),
        .digit_stall (digit_stall),
        .digit_char  (digit_char),
        .last_digit  (last_digit)
    );

    // a digit that is not the last one is always followed by another
    a_run_continues: assert property (@(posedge clk) disable iff (!rst_n)
        digit_valid && !digit_stall && !last_digit |=> digit_valid)
        else $error("digit run broken before its last digit");

    // the converter only refuses input when its first stage is occupied
    a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
        value_stall |-> st_valid[1])
        else $error("input stalled with an empty first stage");

    // every digit shown is a decimal ascii digit
    a_char_range: assert property (@(posedge clk) disable iff (!rst_n)
        digit_valid |-> (digit_char >= udta_pkg::ASCII_ZERO)
                        && (digit_char <= udta_pkg::ASCII_ZERO + 6'd9))
        else $error("digit character out of range");

endmodule

// ===== verif/udta_checker.sv =====
// digit stream checker for the unsigned decimal to ascii converter
// watches both channels, predicts the digits of each value and compares them
// depends on udta_pkg for the character width and the ascii zero code
`timescale 1ns / 1ps

module udta_checker #(
    parameter int VALUE_WIDTH = udta_pkg::VALUE_WIDTH_DEF,
    parameter int MAX_DIGITS  = udta_pkg::MAX_DIGITS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          value_valid,
    input  logic                          value_stall,
    input  logic [VALUE_WIDTH-1:0]        value,
    input  logic                          digit_valid,
    input  logic                          digit_stall,
    input  logic [udta_pkg::CHAR_W-1:0]   digit_char,
    input  logic                          last_digit,
    output int                            fail_count,
    output int                            digits_pending,
    output int                            values_seen,
    output int                            digits_seen
);

    localparam int RADIX     = 10;
    localparam int PRINT_CAP = 40;
    localparam int PAD_W     = udta_pkg::CHAR_W - udta_pkg::DIGIT_W;

    typedef struct packed {
        logic [udta_pkg::CHAR_W-1:0] ch;
        logic                        last;
    } digit_t;

    digit_t digits_due[$];
    digit_t due;
    int     errors;
    int     n_values;
    int     n_digits;

    task automatic report_mismatch(input string msg);
        errors++;
        if (errors <= PRINT_CAP)
            $display("%0t ns: digit check: %s", $time, msg);
    endtask

    // decimal expansion, most significant digit queued first
    task automatic queue_decimal(input logic [VALUE_WIDTH-1:0] v);
        logic [udta_pkg::DIGIT_W-1:0] lsd_first [MAX_DIGITS];
        bit [63:0] rest;
        bit [63:0] rem;
        int        count;
        digit_t    d;
        rest = '0;
        rest[VALUE_WIDTH-1:0] = v;
        count = 0;
        do begin
            rem = rest % RADIX;
            lsd_first[count] = rem[udta_pkg::DIGIT_W-1:0];
            rest = rest / RADIX;
            count++;
        end while (rest != 0 && count < MAX_DIGITS);
        for (int k = count - 1; k >= 0; k--) begin
            d.ch   = udta_pkg::ASCII_ZERO + {{PAD_W{1'b0}}, lsd_first[k]};
            d.last = (k == 0);
            digits_due.push_back(d);
        end
    endtask

    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            digits_due.delete();
            errors         = 0;
            n_values       = 0;
            n_digits       = 0;
            fail_count     <= 0;
            digits_pending <= 0;
            values_seen    <= 0;
            digits_seen    <= 0;
        end
        else begin
            if (digit_valid && !digit_stall) begin
                n_digits++;
                if (digits_due.size() == 0) begin
                    report_mismatch($sformatf("digit %0d last=%0b with nothing due",
                                              digit_char, last_digit));
                end
                else begin
                    due = digits_due.pop_front();
                    if (digit_char !== due.ch)
                        report_mismatch($sformatf("char %0d, wanted %0d",
                                                  digit_char, due.ch));
                    if (last_digit !== due.last)
                        report_mismatch($sformatf("last flag %0b, wanted %0b",
                                                  last_digit, due.last));
                end
            end
            if (value_valid && !value_stall) begin
                n_values++;
                queue_decimal(value);
            end
            fail_count     <= errors;
            digits_pending <= digits_due.size();
            values_seen    <= n_values;
            digits_seen    <= n_digits;
        end
    end

endmodule

// ===== verif/unsigned_decimal_to_ascii_test.sv =====
// top of the unsigned decimal to ascii testbench: clock, reset, stimulus, verdict
// drives the value channel and the digit stall, relies on udta_checker for checking
// depends on udta_pkg, unsigned_decimal_to_ascii and udta_checker
`timescale 1ns / 1ps

module unsigned_decimal_to_ascii_test;

    localparam int VALUE_WIDTH = udta_pkg::VALUE_WIDTH_DEF;
    localparam int MAX_DIGITS  = udta_pkg::MAX_DIGITS_DEF;

    // first digit shows at the emitter register behind the last dabble stage
    localparam int LATENCY = (VALUE_WIDTH + udta_pkg::STEP_BITS - 1) / udta_pkg::STEP_BITS + 1;

    localparam int RANDOM_VALUES  = 430;
    localparam int IDLE_PCT       = 6;
    localparam int MAX_GAP        = 4;
    localparam int QUIET_FIRST    = 150;
    localparam int QUIET_LAST     = 270;
    localparam int RESET_CYCLES   = 9;
    // cycles without any transfer before the run is declared hung
    localparam int WATCHDOG_LIMIT = 2000;

    logic                          clk         = 1'b0;
    logic                          rst_n       = 1'b0;
    logic                          value_valid = 1'b0;
    logic [VALUE_WIDTH-1:0]        value       = '0;
    logic                          digit_stall = 1'b0;
    logic                          value_stall;
    logic                          digit_valid;
    logic [udta_pkg::CHAR_W-1:0]   digit_char;
    logic                          last_digit;

    // high during the stretch where neither side idles
    logic quiet = 1'b0;

    int fail_count;
    int digits_pending;
    int values_seen;
    int digits_seen;
    int stuck_cycles;

    unsigned_decimal_to_ascii #(
        .VALUE_WIDTH (VALUE_WIDTH),
        .MAX_DIGITS  (MAX_DIGITS)
    ) uut (
        .clk         (clk),
        .rst_n       (rst_n),
        .value_valid (value_valid),
        .value_stall (value_stall),
        .value       (value),
        .digit_valid (digit_valid),
        .digit_stall (digit_stall),
        .digit_char  (digit_char),
        .last_digit  (last_digit)
    );

    udta_checker #(
        .VALUE_WIDTH (VALUE_WIDTH),
        .MAX_DIGITS  (MAX_DIGITS)
    ) digit_watch (
        .clk            (clk),
        .rst_n          (rst_n),
        .value_valid    (value_valid),
        .value_stall    (value_stall),
        .value          (value),
        .digit_valid    (digit_valid),
        .digit_stall    (digit_stall),
        .digit_char     (digit_char),
        .last_digit     (last_digit),
        .fail_count     (fail_count),
        .digits_pending (digits_pending),
        .values_seen    (values_seen),
        .digits_seen    (digits_seen)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    // receiver back-pressure: random stalls at about IDLE_PCT percent,
    // none at all during the quiet stretch
    always @(posedge clk)
    begin
        digit_stall <= !quiet && ($urandom_range(0, 99) < IDLE_PCT);
    end

    // count cycles in which neither channel completes a transfer
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            stuck_cycles <= 0;
        else if ((value_valid && !value_stall) || (digit_valid && !digit_stall))
            stuck_cycles <= 0;
        else
            stuck_cycles <= stuck_cycles + 1;
    end

    initial
    begin
        while (stuck_cycles < WATCHDOG_LIMIT)
            @(posedge clk);
        $display("TEST FAILED");
        $finish;
    end

    // one transfer on the value channel; an occasional idle gap goes first,
    // and the payload holds until the block takes it
    task automatic send_value(input logic [VALUE_WIDTH-1:0] v);
        int gap;
        if (!quiet && $urandom_range(0, 99) < IDLE_PCT) begin
            gap = $urandom_range(1, MAX_GAP);
            value_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        value_valid <= 1'b1;
        value       <= v;
        @(posedge clk);
        while (value_stall)
            @(posedge clk);
    endtask

    // random value: mostly full-width words and values of a chosen digit
    // count, plus small numbers and neighbors of powers of ten
    function automatic logic [VALUE_WIDTH-1:0] random_value();
        bit [63:0] top_v;
        bit [63:0] lo;
        bit [63:0] hi;
        bit [63:0] pick;
        int        mode;
        int        n;
        top_v = {64{1'b1}} >> (64 - VALUE_WIDTH);
        mode  = $urandom_range(0, 9);
        pick  = {$urandom, $urandom};
        if (mode < 4) begin
            pick = pick & top_v;
        end
        else if (mode < 8) begin
            // a 32-bit value has one to ten decimal digits
            n  = $urandom_range(1, 10);
            lo = 1;
            repeat (n - 1) lo = lo * 10;
            hi = lo * 10 - 1;
            if (hi > top_v)
                hi = top_v;
            pick = (n == 1) ? pick % 10 : lo + pick % (hi - lo + 1);
        end
        else if (mode == 8) begin
            pick = $urandom_range(0, 20);
        end
        else begin
            n  = $urandom_range(0, 9);
            lo = 1;
            repeat (n) lo = lo * 10;
            pick = lo + $urandom_range(0, 2) - 1;
            if (pick > top_v)
                pick = top_v;
        end
        return pick[VALUE_WIDTH-1:0];
    endfunction

    initial
    begin
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // zero is the only value whose sole digit is a zero
        send_value(32'd0);
        send_value(32'd1);
        send_value(32'd9);
        // digit count steps up at each power of ten
        send_value(32'd10);
        send_value(32'd99);
        send_value(32'd100);
        send_value(32'd101);
        send_value(32'd999);
        send_value(32'd1000);
        send_value(32'd65535);
        send_value(32'd65536);
        send_value(32'd99999999);
        send_value(32'd100000000);
        send_value(32'd999999999);
        // ten-digit values, zeros inside and at the tail
        send_value(32'd1000000000);
        send_value(32'd1000000001);
        send_value(32'd1234567890);
        send_value(32'd2147483647);
        send_value(32'd2147483648);
        send_value(32'hAAAAAAAA);
        send_value(32'h55555555);
        send_value(32'd4000000000);
        // largest values, ten digits all significant
        send_value(32'd4294967294);
        send_value(32'd4294967295);
        send_value(32'd0);

        for (int i = 0; i < RANDOM_VALUES; i++) begin
            quiet <= (i >= QUIET_FIRST) && (i < QUIET_LAST);
            send_value(random_value());
        end
        value_valid <= 1'b0;
        quiet       <= 1'b0;

        // pending count is registered, so let it catch the last transfer
        @(posedge clk);
        while (digits_pending != 0)
            @(posedge clk);
        repeat (2 * LATENCY) @(posedge clk);

        $display("covered %0d values (%0d directed corners, %0d random), %0d digits out",
                 values_seen, values_seen - RANDOM_VALUES, RANDOM_VALUES, digits_seen);
        $display("random part: full-width words, every digit count, powers of ten, %0s",
                 "random idling on both sides with one stretch free of it");
        if (fail_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
